@@ hw/rtl/dsdw_pkg.sv @@
// Package for the DSD word capture and rate detect block.
// Holds item structs, window table, codes and helpers; no dependencies.
`timescale 1ns / 1ps

package dsdw_pkg;

    // Block configuration
    localparam int LANES       = 2;
    localparam int RING_DEPTH  = 512;
    localparam int BLOCK_WORDS = 4;
    localparam int NUM_FMT     = 8;

    // Derived widths
    localparam int POS_W  = $clog2(RING_DEPTH);
    localparam int SLOT_W = $clog2(BLOCK_WORDS);
    localparam int IDX_W  = 7;
    localparam int FMT_W  = $clog2(NUM_FMT);
    localparam int SEL_W  = (LANES + 1 > 1) ? $clog2(LANES + 1) : 1;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int WIN_W  = 11;

    // Operation codes of an input item
    typedef enum logic {
        OP_ARM     = 1'b0,
        OP_CAPTURE = 1'b1
    } op_t;

    // Kind codes of a result item
    typedef enum logic {
        KIND_FORMAT = 1'b0,
        KIND_BLOCK  = 1'b1
    } kind_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] timestamp;
        logic [31:0] data_lane0;
        logic [31:0] data_lane1;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic        lane;
        logic [6:0]  block_index;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
        logic [15:0] base_rate;
        logic [9:0]  rate_multiple;
        logic        last;
    } out_item_t;

    // One format window: gap range in timer ticks and what it means
    typedef struct packed {
        logic [WIN_W-1:0] lo;
        logic [WIN_W-1:0] hi;
        logic [15:0]      base_rate;
        logic [9:0]       rate_multiple;
    } fmt_win_t;

    localparam fmt_win_t FMT_TABLE [NUM_FMT] = '{
        '{11'd140,  11'd144,  16'd44100, 10'd512},
        '{11'd128,  11'd132,  16'd48000, 10'd512},
        '{11'd281,  11'd285,  16'd44100, 10'd256},
        '{11'd258,  11'd262,  16'd48000, 10'd256},
        '{11'd565,  11'd569,  16'd44100, 10'd128},
        '{11'd518,  11'd522,  16'd48000, 10'd128},
        '{11'd1132, 11'd1136, 16'd44100, 10'd64},
        '{11'd1040, 11'd1044, 16'd48000, 10'd64}
    };

    // Detector result for one capture
    typedef struct packed {
        logic        hit;
        logic [15:0] base_rate;
        logic [9:0]  rate_multiple;
    } det_res_t;

    // Staging result for one capture
    typedef struct packed {
        logic                                     done;
        logic [IDX_W-1:0]                         block_index;
        logic [LANES-1:0][BLOCK_WORDS-1:0][31:0]  words;
    } blk_res_t;

    function automatic logic [31:0] bit_reverse(input logic [31:0] v);
        logic [31:0] r;
        for (int b = 0; b < 32; b++)
        begin
            r[b] = v[31 - b];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/dsdw_detect.sv @@
// Rate detector: capture gap, current format window, first-match search.
// Depends on dsdw_pkg.
`timescale 1ns / 1ps

module dsdw_detect (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              arm_go,
    input  logic              capture_go,
    input  logic [31:0]       timestamp,
    output dsdw_pkg::det_res_t det
);
    import dsdw_pkg::*;

    logic [31:0]      prev_time_reg;
    logic [FMT_W-1:0] fmt_reg;
    logic             armed_reg;

    logic [31:0]        gap;
    logic [NUM_FMT-1:0] in_win;
    logic               out_cur;
    logic               found;
    logic [FMT_W-1:0]   sel;
    fmt_win_t           cur_win;

    // Wrapping gap against the previous capture
    assign gap = timestamp - prev_time_reg;

    // Window hits, lowest index wins
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < NUM_FMT; i++)
        begin
            in_win[i] = (gap >= 32'(FMT_TABLE[i].lo)) && (gap <= 32'(FMT_TABLE[i].hi));
        end
        for (int i = NUM_FMT - 1; i >= 0; i--)
        begin
            if (in_win[i])
            begin
                found = 1'b1;
                sel   = FMT_W'(i);
            end
        end
    end

    assign cur_win = FMT_TABLE[fmt_reg];
    assign out_cur = (gap < 32'(cur_win.lo)) || (gap > 32'(cur_win.hi));

    always_comb
    begin
        det.hit           = armed_reg && out_cur && found;
        det.base_rate     = FMT_TABLE[sel].base_rate;
        det.rate_multiple = FMT_TABLE[sel].rate_multiple;
    end

    // Detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            fmt_reg       <= '0;
            armed_reg     <= 1'b0;
        end
        else
        begin
            if (arm_go)
            begin
                armed_reg <= 1'b1;
            end
            if (capture_go)
            begin
                prev_time_reg <= timestamp;
                if (det.hit)
                begin
                    fmt_reg <= sel;
                end
            end
        end
    end

endmodule

@@ hw/rtl/dsdw_stage.sv @@
// Word staging: bit reversal, per-lane four-word blocks, ring position.
// Depends on dsdw_pkg.
`timescale 1ns / 1ps

module dsdw_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capture_go,
    input  logic [31:0]        data_lane0,
    input  logic [31:0]        data_lane1,
    output dsdw_pkg::blk_res_t blk
);
    import dsdw_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      staged_reg [LANES][BLOCK_WORDS];

    logic [SLOT_W-1:0] slot;
    logic [31:0]       rev [LANES];

    assign slot = pos_reg[SLOT_W-1:0];

    // Reversed lane words
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rev[l] = bit_reverse((l == 0) ? data_lane0 : data_lane1);
        end
    end

    // Block completes on the last slot; word for the current slot bypasses
    always_comb
    begin
        blk.done        = (slot == SLOT_W'(BLOCK_WORDS - 1));
        blk.block_index = IDX_W'(pos_reg >> SLOT_W);
        for (int l = 0; l < LANES; l++)
        begin
            for (int s = 0; s < BLOCK_WORDS; s++)
            begin
                blk.words[l][s] = (slot == SLOT_W'(s)) ? rev[l] : staged_reg[l][s];
            end
        end
    end

    // Ring position wraps at the ring depth
    always_comb
    begin
        if (pos_reg == POS_W'(RING_DEPTH - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (capture_go)
        begin
            pos_reg <= pos_next;
        end
    end

    // Staging words, written at the current slot
    always_ff @(posedge clk)
    begin
        if (capture_go)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                staged_reg[l][slot] <= rev[l];
            end
        end
    end

endmodule

@@ hw/rtl/dsdw_emit.sv @@
// Result register and sequencer: holds the results of one capture and
// hands them out one item per cycle while out_stall is low. Depends on dsdw_pkg.
`timescale 1ns / 1ps

module dsdw_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dsdw_pkg::det_res_t  det,
    input  dsdw_pkg::blk_res_t  blk,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output dsdw_pkg::out_item_t out_item
);
    import dsdw_pkg::*;

    // bit 0: format report, bit l+1: block of lane l
    logic [LANES:0]   pend_reg;
    logic [LANES:0]   pend_next;
    logic [15:0]      base_reg;
    logic [9:0]       mult_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [LANES-1:0][BLOCK_WORDS-1:0][31:0] words_reg;

    logic [LANES:0]   low_bit;
    logic [SEL_W-1:0] sel;
    logic [LANE_W-1:0] lane_idx;
    logic             is_last;
    logic             take;

    assign out_valid = |pend_reg;
    assign take      = out_valid && !out_stall;
    assign low_bit   = pend_reg & (~pend_reg + (LANES + 1)'(1));
    assign is_last   = (pend_reg & (pend_reg - (LANES + 1)'(1))) == '0;
    assign free      = !out_valid || (take && is_last);

    // Lowest pending result goes out first
    always_comb
    begin
        sel = '0;
        for (int i = LANES; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = SEL_W'(i);
            end
        end
    end

    assign lane_idx = LANE_W'(sel - SEL_W'(1));

    // Output payload
    always_comb
    begin
        out_item      = '0;
        out_item.last = is_last;
        if (sel == '0)
        begin
            out_item.kind          = KIND_FORMAT;
            out_item.base_rate     = base_reg;
            out_item.rate_multiple = mult_reg;
        end
        else
        begin
            out_item.kind        = KIND_BLOCK;
            out_item.lane        = 1'(lane_idx);
            out_item.block_index = idx_reg;
            out_item.word0       = words_reg[lane_idx][0];
            out_item.word1       = words_reg[lane_idx][1];
            out_item.word2       = words_reg[lane_idx][2];
            out_item.word3       = words_reg[lane_idx][3];
        end
    end

    // Pending mask
    always_comb
    begin
        pend_next = pend_reg;
        if (take)
        begin
            pend_next = pend_reg & ~low_bit;
        end
        if (load)
        begin
            pend_next[0] = det.hit;
            for (int l = 0; l < LANES; l++)
            begin
                pend_next[l + 1] = blk.done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            base_reg  <= det.base_rate;
            mult_reg  <= det.rate_multiple;
            idx_reg   <= blk.block_index;
            words_reg <= blk.words;
        end
    end

endmodule

@@ hw/rtl/dsd_word_capture_rate_detect.sv @@
// Top level of the DSD word capture and rate detect block.
// Depends on dsdw_pkg, dsdw_detect, dsdw_stage, dsdw_emit.
`timescale 1ns / 1ps

// Usage:
// - in channel (in_valid/in_stall/in_item): an arm item sets detection;
//   a capture item stages one bit-reversed word per lane and measures the
//   timer gap since the previous capture.
// - out channel (out_valid/out_stall/out_item): per capture, a format report
//   if the gap picked a new format, then one block item per lane when a
//   four-word block completes; last marks the final item of a capture.
// - An accepted item is held in the input register and then processed into
//   the result register, from which its first result can be taken.
// - Throughput: one input item per cycle while each causes at most one
//   result and out_stall is low; the result register hands out one item
//   per cycle while out_stall is low, so after a capture that completes a
//   block the next capture waits until its items have gone out.
// - Reset clears detection, format, previous timer value and ring position;
//   staged words are only read after they were written.
// - A stalled receiver holds the current result; arm items still pass, but
//   the next capture waits in the input register while the result register
//   is busy, and in_stall rises.

module dsd_word_capture_rate_detect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dsdw_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output dsdw_pkg::out_item_t out_item
);
    import dsdw_pkg::*;

    logic     in_valid_reg;
    in_item_t in_reg;

    logic     emit_free;
    logic     core_take;
    logic     arm_go;
    logic     capture_go;
    logic     load;
    det_res_t det;
    blk_res_t blk;

    // Processing takes a held arm item at once, and a held capture when results have room
    assign core_take  = in_valid_reg && ((in_reg.operation == OP_ARM) || emit_free);
    assign arm_go     = core_take && (in_reg.operation == OP_ARM);
    assign capture_go = core_take && (in_reg.operation == OP_CAPTURE);
    assign load       = capture_go && (det.hit || blk.done);
    assign in_stall   = in_valid_reg && !core_take;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (core_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_reg <= in_item;
        end
    end

    dsdw_detect u_detect (
        .clk        (clk),
        .rst_n      (rst_n),
        .arm_go     (arm_go),
        .capture_go (capture_go),
        .timestamp  (in_reg.timestamp),
        .det        (det)
    );

    dsdw_stage u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture_go (capture_go),
        .data_lane0 (in_reg.data_lane0),
        .data_lane1 (in_reg.data_lane1),
        .blk        (blk)
    );

    dsdw_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .det       (det),
        .blk       (blk),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
